@@ hdl/skbs_pkg.sv @@
// Shared constants and types for the sorted key binary search block.
package skbs_pkg;

  localparam int DEPTH = 1024;
  localparam int AW = $clog2(DEPTH);
  localparam int IDX_W = 12;
  localparam int SLOT_W = 10;
  localparam int KEY_W = 32;
  localparam int LAST_W = 11;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef logic signed [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic                    is_search;
    logic                    is_empty;
    logic [AW-1:0]           slot;
    logic signed [KEY_W-1:0] key;
    idx_t                    lo;
    idx_t                    hi;
  } cmd_t;

endpackage

@@ hdl/sorted_key_binary_search.sv @@
// Top level of the sorted key binary search block.
// Input side is a queue: present an item with push while full is low.
// func 0 loads in_key into table slot in_slot and gives no result;
// func 1 searches the slot range first_index..last_index for in_key.
// The table must hold keys in ascending signed order over searched ranges.
// Result side is a queue: while empty is low, out_found and out_position
// show the oldest result; pop takes it. Each search gives one result.
// A two-entry command queue separates the front end from the engine, so
// items keep being accepted while a result waits to be popped.
// A load is written into the table as the engine takes it. A search over an
// empty range writes its result as it is taken; any other first issues its
// first probe and then checks one probe per cycle, at most log2(1024)+1 = 11
// probes, each against the registered table read for that probe.
// A new search starts only once the result register is free; when pop is
// held low, results and then commands back up and full rises.
// Reset clears both queues and the engine; table contents stay undefined
// until loaded.
module sorted_key_binary_search import skbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic                     in_func,
  input  logic [SLOT_W-1:0]        in_slot,
  input  logic signed [KEY_W-1:0]  in_key,
  input  logic [SLOT_W-1:0]        in_first_index,
  input  logic signed [LAST_W-1:0] in_last_index,
  output logic                     empty,
  input  logic                     pop,
  output logic                     out_found,
  output logic [SLOT_W-1:0]        out_position
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  skbs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_key         (in_key),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_take       (cmd_take)
  );

  skbs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .empty        (empty),
    .pop          (pop),
    .out_found    (out_found),
    .out_position (out_position)
  );

endmodule

@@ hdl/skbs_front.sv @@
// Front end: accept items, classify them and queue commands for the search engine.
module skbs_front import skbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic                     in_func,
  input  logic [SLOT_W-1:0]        in_slot,
  input  logic signed [KEY_W-1:0]  in_key,
  input  logic [SLOT_W-1:0]        in_first_index,
  input  logic signed [LAST_W-1:0] in_last_index,
  output logic                     cmd_valid,
  output cmd_t                     cmd,
  input  logic                     cmd_take
);

  cmd_t       q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  cmd_t       new_cmd;
  logic       keep;
  logic       wr;
  logic       rd;
  idx_t       lo_ext;
  idx_t       last_ext;
  idx_t       hi_sat;

  assign full = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rp_r];

  always_comb begin
    lo_ext = idx_t'({1'b0, in_first_index});
    last_ext = idx_t'(in_last_index);
    if (int'(in_last_index) > DEPTH - 1) begin
      hi_sat = idx_t'(DEPTH - 1);
    end else begin
      hi_sat = last_ext;
    end
    new_cmd.is_search = (in_func == FUNC_SEARCH);
    new_cmd.is_empty = (hi_sat < lo_ext);
    new_cmd.slot = AW'(in_slot);
    new_cmd.key = in_key;
    new_cmd.lo = lo_ext;
    new_cmd.hi = hi_sat;
    // drop loads aimed past the table
    keep = (in_func == FUNC_SEARCH) || (int'(in_slot) < DEPTH);
  end

  assign wr = push && !full && keep;
  assign rd = cmd_valid && cmd_take;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        wp_r <= !wp_r;
      end
      if (rd) begin
        rp_r <= !rp_r;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

@@ hdl/skbs_back.sv @@
// Back end: key table, probe sequencer and result register.
module skbs_back import skbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_take,
  output logic              empty,
  input  logic              pop,
  output logic              out_found,
  output logic [SLOT_W-1:0] out_position
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PROBE = 1'b1;

  logic signed [KEY_W-1:0] mem [DEPTH];
  logic signed [KEY_W-1:0] rdata_r;

  logic                    state_r;
  logic                    state_nxt;
  idx_t                    lo_r;
  idx_t                    lo_nxt;
  idx_t                    hi_r;
  idx_t                    hi_nxt;
  idx_t                    mid_r;
  idx_t                    mid_nxt;
  logic signed [KEY_W-1:0] target_r;
  logic signed [KEY_W-1:0] target_nxt;
  logic                    out_valid_r;
  logic                    found_r;
  logic [SLOT_W-1:0]       position_r;

  logic                    we;
  logic                    res_wr;
  logic                    res_found;
  logic [SLOT_W-1:0]       res_pos;
  logic signed [IDX_W:0]   sum;

  assign empty = !out_valid_r;
  assign out_found = found_r;
  assign out_position = position_r;

  always_comb begin
    state_nxt = state_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    target_nxt = target_r;
    cmd_take = 1'b0;
    we = 1'b0;
    res_wr = 1'b0;
    res_found = 1'b0;
    res_pos = '0;
    sum = '0;
    unique case (state_r)
      ST_IDLE: begin
        lo_nxt = cmd.lo;
        hi_nxt = cmd.hi;
        target_nxt = cmd.key;
        if (cmd_valid) begin
          if (!cmd.is_search) begin
            cmd_take = 1'b1;
            we = 1'b1;
          end else if (!out_valid_r) begin
            cmd_take = 1'b1;
            if (cmd.is_empty) begin
              res_wr = 1'b1;
            end else begin
              state_nxt = ST_PROBE;
            end
          end
        end
      end
      ST_PROBE: begin
        if (rdata_r == target_r) begin
          res_wr = 1'b1;
          res_found = 1'b1;
          res_pos = SLOT_W'(mid_r);
          state_nxt = ST_IDLE;
        end else begin
          if (rdata_r < target_r) begin
            lo_nxt = mid_r + idx_t'(1);
          end else begin
            hi_nxt = mid_r - idx_t'(1);
          end
          if (hi_nxt < lo_nxt) begin
            res_wr = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    sum = (IDX_W+1)'(lo_nxt) + (IDX_W+1)'(hi_nxt);
    mid_nxt = sum[IDX_W:1];
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[cmd.slot] <= cmd.key;
    end
    rdata_r <= mem[AW'($unsigned(mid_nxt))];
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    mid_r <= mid_nxt;
    target_r <= target_nxt;
    if (res_wr) begin
      found_r <= res_found;
      position_r <= res_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_wr) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ verif/sorted_key_binary_search_tb.sv @@
// Self-checking testbench for sorted_key_binary_search: directed table, then random load and search traffic.
module sorted_key_binary_search_tb;
  import skbs_pkg::*;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] position;
  } match_t;

  typedef struct {
    logic                     func;
    logic [SLOT_W-1:0]        slot;
    logic signed [KEY_W-1:0]  key;
    logic [SLOT_W-1:0]        first;
    logic signed [LAST_W-1:0] last;
    bit                       typed;
    match_t                   want;
  } stim_row_t;

  localparam int ITEM_TARGET = 1050;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_SHOWN = 10;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     push = 1'b0;
  logic                     in_func = FUNC_LOAD;
  logic [SLOT_W-1:0]        in_slot = '0;
  logic signed [KEY_W-1:0]  in_key = '0;
  logic [SLOT_W-1:0]        in_first_index = '0;
  logic signed [LAST_W-1:0] in_last_index = '0;
  logic                     pop = 1'b0;
  logic                     full;
  logic                     empty;
  logic                     out_found;
  logic [SLOT_W-1:0]        out_position;

  sorted_key_binary_search u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_key         (in_key),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .empty          (empty),
    .pop            (pop),
    .out_found      (out_found),
    .out_position   (out_position)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic signed [KEY_W-1:0] key_table [DEPTH];
  bit                      loaded [DEPTH];
  match_t                  match_q [$];
  int                      items_sent = 0;
  int                      errors = 0;
  bit                      calm = 1'b0;
  bit                      hold_req = 1'b0;

  // Walk the probe sequence; return 0 if any probe lands on a slot never loaded.
  function automatic bit lookup_key(input logic [SLOT_W-1:0] first,
                                    input logic signed [LAST_W-1:0] last,
                                    input logic signed [KEY_W-1:0] key,
                                    output match_t hit);
    int lo;
    int hi;
    int mid;
    bit ok;
    bit done;
    lo = first;
    hi = last;
    if (hi > DEPTH - 1) begin
      hi = DEPTH - 1;
    end
    hit = '0;
    ok = 1'b1;
    done = 1'b0;
    while (!done && lo <= hi) begin
      mid = (lo + hi) / 2;
      if (!loaded[mid]) begin
        ok = 1'b0;
        done = 1'b1;
      end else if (key_table[mid] == key) begin
        hit.found = 1'b1;
        hit.position = SLOT_W'(mid);
        done = 1'b1;
      end else if (key_table[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return ok;
  endfunction

  function automatic stim_row_t mk(input logic func, input int slot,
                                   input logic signed [KEY_W-1:0] key, input int first,
                                   input int last, input bit typed, input logic found,
                                   input int pos);
    stim_row_t r;
    r.func = func;
    r.slot = SLOT_W'(slot);
    r.key = key;
    r.first = SLOT_W'(first);
    r.last = LAST_W'(last);
    r.typed = typed;
    r.want.found = found;
    r.want.position = SLOT_W'(pos);
    return r;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) begin
      $display("mismatch: %s", msg);
    end
  endtask

  task automatic send_item(input logic func, input logic [SLOT_W-1:0] slot,
                           input logic signed [KEY_W-1:0] key,
                           input logic [SLOT_W-1:0] first,
                           input logic signed [LAST_W-1:0] last, input match_t want);
    while (!calm && $urandom_range(99) < 32) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_func <= func;
    in_slot <= slot;
    in_key <= key;
    in_first_index <= first;
    in_last_index <= last;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    items_sent++;
    if (func == FUNC_LOAD) begin
      key_table[slot] = key;
      loaded[slot] = 1'b1;
    end else begin
      match_q.push_back(want);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (match_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic try_search(input int first, input int last_v,
                            input logic signed [KEY_W-1:0] key, output bit ok);
    match_t hit;
    ok = lookup_key(SLOT_W'(first), LAST_W'(last_v), key, hit);
    if (ok) begin
      send_item(FUNC_SEARCH, SLOT_W'($urandom), key, SLOT_W'(first), LAST_W'(last_v), hit);
    end
  endtask

  task automatic empty_search();
    int first;
    bit ok;
    first = $urandom_range(0, DEPTH - 1);
    try_search(first, int'($urandom_range(0, first + 1023)) - 1024, $urandom, ok);
  endtask

  // Load a short ascending run of keys, then search inside it.
  task automatic load_run();
    int base;
    int len;
    int j;
    int first;
    int last_v;
    logic signed [KEY_W-1:0] run_keys [16];
    logic signed [KEY_W-1:0] v;
    logic signed [KEY_W-1:0] key;
    bit ok;
    len = $urandom_range(1, 16);
    base = $urandom_range(0, DEPTH - 1);
    if (base + len > DEPTH) begin
      base = DEPTH - len;
    end
    for (int i = 0; i < len; i++) begin
      run_keys[i] = (i > 0 && $urandom_range(7) == 0) ? run_keys[i-1] : $urandom;
    end
    for (int i = 1; i < len; i++) begin
      v = run_keys[i];
      j = i - 1;
      while (j >= 0 && run_keys[j] > v) begin
        run_keys[j+1] = run_keys[j];
        j--;
      end
      run_keys[j+1] = v;
    end
    for (int i = 0; i < len; i++) begin
      send_item(FUNC_LOAD, SLOT_W'(base + i), run_keys[i], SLOT_W'($urandom),
                LAST_W'($urandom), '0);
    end
    repeat ($urandom_range(1, 5)) begin
      first = base + $urandom_range(0, len - 1);
      last_v = first - 1 + $urandom_range(0, base + len - first);
      if ($urandom_range(3) != 0) begin
        key = key_table[base + $urandom_range(0, len - 1)];
      end else begin
        key = $urandom;
      end
      try_search(first, last_v, key, ok);
    end
  endtask

  task automatic wide_search();
    int tries;
    int pick;
    bit ok;
    logic signed [KEY_W-1:0] key;
    tries = 0;
    ok = 1'b0;
    while (!ok && tries < 8) begin
      pick = $urandom_range(0, DEPTH - 1);
      key = loaded[pick] ? key_table[pick] : $urandom;
      try_search($urandom_range(0, DEPTH - 1), $urandom_range(0, DEPTH - 1), key, ok);
      tries++;
    end
    if (!ok) begin
      empty_search();
    end
  endtask

  // Result side: check each popped item, randomize pop, honor hold-off requests.
  initial begin
    int hold_left;
    match_t exp_hit;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        if (match_q.size() == 0) begin
          note_error($sformatf("unexpected result found=%0b position=%0d",
                               out_found, out_position));
        end else begin
          exp_hit = match_q.pop_front();
          if (out_found !== exp_hit.found || out_position !== exp_hit.position) begin
            note_error($sformatf("found exp %0b got %0b, position exp %0d got %0d",
                                 exp_hit.found, out_found, exp_hit.position,
                                 out_position));
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= rst_n && (calm || $urandom_range(99) >= 32);
      end
    end
  end

  initial begin
    stim_row_t plan [$];
    match_t hit;
    int pick;
    bit hold_done;
    bit pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    plan.push_back(mk(FUNC_SEARCH, 0, 0, 0, -1, 1, 1'b0, 0));
    plan.push_back(mk(FUNC_SEARCH, 1023, KEY_MAX, 1023, -1024, 1, 1'b0, 0));
    plan.push_back(mk(FUNC_SEARCH, 0, KEY_MIN, 1023, 1022, 1, 1'b0, 0));
    plan.push_back(mk(FUNC_LOAD, 0, KEY_MIN, 1023, 1023, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_LOAD, 1023, KEY_MAX, 0, -1, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_SEARCH, 0, KEY_MIN, 0, 0, 1, 1'b1, 0));
    plan.push_back(mk(FUNC_SEARCH, 0, KEY_MAX, 1023, 1023, 1, 1'b1, 1023));
    plan.push_back(mk(FUNC_SEARCH, 0, 5, 0, 0, 1, 1'b0, 0));
    plan.push_back(mk(FUNC_SEARCH, 0, KEY_MIN, 1023, 1023, 1, 1'b0, 0));
    plan.push_back(mk(FUNC_LOAD, 1, -100, 0, 0, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_LOAD, 2, -1, 0, 0, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_LOAD, 3, 0, 0, 0, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_LOAD, 4, 1, 0, 0, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_LOAD, 5, 42, 0, 0, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_LOAD, 6, 1000, 0, 0, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_SEARCH, 0, -1, 0, 6, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_SEARCH, 0, 42, 0, 6, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_SEARCH, 0, 2, 0, 6, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_SEARCH, 0, KEY_MAX, 0, 6, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_SEARCH, 0, KEY_MIN, 0, 6, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_LOAD, 3, 5000, 0, 0, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_SEARCH, 0, 5000, 0, 6, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_SEARCH, 0, 0, 0, 6, 0, 1'b0, 0));
    plan.push_back(mk(FUNC_LOAD, 3, 0, 0, 0, 0, 1'b0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].typed) begin
        hit = plan[i].want;
      end else begin
        void'(lookup_key(plan[i].first, plan[i].last, plan[i].key, hit));
      end
      send_item(plan[i].func, plan[i].slot, plan[i].key, plan[i].first, plan[i].last, hit);
    end
    drain();

    while (items_sent < ITEM_TARGET) begin
      if (!hold_done && items_sent >= 300) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      calm = (items_sent >= 550 && items_sent < 700);
      if (!pause_done && items_sent >= 800) begin
        drain();
        pause_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        load_run();
      end else if (pick < 70) begin
        wide_search();
      end else if (pick < 80) begin
        empty_search();
      end else begin
        send_item(FUNC_LOAD, SLOT_W'($urandom), $urandom, SLOT_W'($urandom),
                  LAST_W'($urandom), '0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** sorted_key_binary_search: PASSED **");
    end else begin
      $display("** sorted_key_binary_search: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("** sorted_key_binary_search: FAILED **");
    $finish;
  end

endmodule
